// ----- rtl/core/tcw_pkg.sv -----
// ---------------------------------------------------------------------------
// tcw_pkg: shared types and constants of the text console writer
// Word layouts of both channels, opcodes, control characters, register
// indexes and reset values.
// ---------------------------------------------------------------------------
`default_nettype none

package tcw_pkg;

  typedef struct packed {
    logic [2:0]  opcode;
    logic [7:0]  char_code;
    logic [11:0] operand;
  } tcw_in_t;

  typedef struct packed {
    logic [6:0]  cursor_col;
    logic [4:0]  cursor_row;
    logic [11:0] cursor_offset;
    logic        cursor_visible;
    logic [7:0]  current_attr;
    logic        escape_pending;
    logic [15:0] read_data;
  } tcw_out_t;

  localparam logic [2:0] OP_PUT    = 3'd0;
  localparam logic [2:0] OP_CLEAR  = 3'd1;
  localparam logic [2:0] OP_SCROLL = 3'd2;
  localparam logic [2:0] OP_SETCOL = 3'd3;
  localparam logic [2:0] OP_SETROW = 3'd4;
  localparam logic [2:0] OP_ATTR   = 3'd5;
  localparam logic [2:0] OP_READ   = 3'd6;

  localparam logic [1:0] CFG_COLUMNS = 2'd0;
  localparam logic [1:0] CFG_ROWS    = 2'd1;
  localparam logic [1:0] CFG_TAB     = 2'd2;
  localparam logic [1:0] CFG_CURSOR  = 2'd3;

  localparam logic [7:0] CH_BELL = 8'd7;
  localparam logic [7:0] CH_TAB  = 8'd9;
  localparam logic [7:0] CH_LF   = 8'd10;
  localparam logic [7:0] CH_CR   = 8'd13;
  localparam logic [7:0] CH_BLANK = 8'h20;

  localparam logic [7:0] RESET_ATTR    = 8'h07;
  localparam logic [7:0] RESET_COLUMNS = 8'd80;
  localparam logic [5:0] RESET_ROWS    = 6'd25;
  localparam logic [4:0] RESET_TAB     = 5'd4;

  // Shared divider geometry.
  localparam int DIV_NW = 12;
  localparam int DIV_DW = 9;
  localparam int DIV_CW = 4;

endpackage

`default_nettype wire

// ----- rtl/core/tcw_div.sv -----
// ---------------------------------------------------------------------------
// tcw_div: shared restoring divider
// One quotient bit per cycle; gives quotient and remainder of an unsigned
// 12-bit dividend by a nonzero 9-bit divisor, with a done pulse.
// ---------------------------------------------------------------------------
`default_nettype none

module tcw_div (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire logic                       start,
  input  wire logic [tcw_pkg::DIV_NW-1:0] dividend,
  input  wire logic [tcw_pkg::DIV_DW-1:0] divisor,
  output logic                            done,
  output logic [tcw_pkg::DIV_NW-1:0]      quot,
  output logic [tcw_pkg::DIV_DW-1:0]      rem
);
  import tcw_pkg::*;

  logic              busy;
  logic [DIV_CW-1:0] cnt;
  logic [DIV_DW-1:0] den;
  logic [DIV_DW:0]   shifted;
  logic [DIV_DW:0]   trial;

  assign shifted = {rem, quot[DIV_NW-1]};
  assign trial   = shifted - {1'b0, den};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= DIV_CW'(DIV_NW);
      end else if (busy) begin
        cnt <= cnt - 1'b1;
        if (cnt == DIV_CW'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quot <= dividend;
      rem  <= '0;
      den  <= divisor;
    end else if (busy) begin
      // The remainder stays below the divisor, so a fitting trial never overflows.
      if (shifted >= {1'b0, den}) begin
        rem <= trial[DIV_DW-1:0];
      end else begin
        rem <= shifted[DIV_DW-1:0];
      end
      quot <= {quot[DIV_NW-2:0], shifted >= {1'b0, den}};
    end
  end

endmodule

`default_nettype wire

// ----- rtl/core/text_console_writer_top.sv -----
// ---------------------------------------------------------------------------
// text_console_writer_top: text screen writer with cursor and scrolling
// Interprets put-char, clear, scroll, cursor, attribute and read words
// against a cell store of MAX_COLUMNS x MAX_ROWS 16-bit cells.
// ---------------------------------------------------------------------------
//  channel   direction  handshake              payload
//  in        input      in_valid / in_ready    tcw_in_t
//  out       output     out_valid / out_ready  tcw_out_t
//  cfg       input      cfg_write              cfg_index, cfg_data
//
// A carriage return, bell or attribute word, or a printable character that does
// not wrap, goes straight to the finishing step; setting a column or row waits
// on the shared divider, a tab on the divider, once more if it wraps, plus any
// scroll sweep. Clear and scroll sweep the store one cell a cycle through the
// single write port. After reset a clearing pass over all MAX_COLUMNS x MAX_ROWS
// cells runs before the first word is taken. A waiting output word holds the
// next word in its finishing step, and the input stalls until the word is taken.
// ---------------------------------------------------------------------------
`default_nettype none

module text_console_writer_top #(
  parameter int MAX_COLUMNS = 128,
  parameter int MAX_ROWS    = 32
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             in_valid,
  output logic                  in_ready,
  input  wire tcw_pkg::tcw_in_t in_data,
  output logic                  out_valid,
  input  wire logic             out_ready,
  output tcw_pkg::tcw_out_t     out_data,
  input  wire logic             cfg_write,
  input  wire logic [1:0]       cfg_index,
  input  wire logic [7:0]       cfg_data
);
  import tcw_pkg::*;

  localparam int CELLS = MAX_COLUMNS * MAX_ROWS;
  localparam int AW    = $clog2(CELLS);
  localparam int CNTW  = $clog2(CELLS + 1);
  localparam int CW    = $clog2(MAX_COLUMNS + 1);
  localparam int COLW  = $clog2(MAX_COLUMNS);
  localparam int HW    = $clog2(MAX_ROWS + 1);
  localparam int LNW   = $clog2(MAX_ROWS);
  localparam int PW    = HW + CW;

  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_DIVW = 4'd1;
  localparam logic [3:0] S_TAB  = 4'd2;
  localparam logic [3:0] S_LF   = 4'd3;
  localparam logic [3:0] S_SCRA = 4'd4;
  localparam logic [3:0] S_SCRB = 4'd5;
  localparam logic [3:0] S_COPY = 4'd6;
  localparam logic [3:0] S_FILL = 4'd7;
  localparam logic [3:0] S_RD   = 4'd8;
  localparam logic [3:0] S_FIN  = 4'd9;

  localparam logic [1:0] DP_COL  = 2'd0;
  localparam logic [1:0] DP_ROW  = 2'd1;
  localparam logic [1:0] DP_TAB1 = 2'd2;
  localparam logic [1:0] DP_TAB2 = 2'd3;

  // Configuration.
  logic [7:0] columns;
  logic [5:0] rows;
  logic [4:0] tab_width;
  logic       cursor_enable;

  // Console state.
  logic [COLW-1:0] cur_col;
  logic [LNW-1:0]  cur_line;
  logic [7:0]      attr;
  logic            escape;

  // Sequencer.
  logic [3:0]      state;
  logic            booting;
  logic [1:0]      purpose;
  logic [11:0]     lines;
  logic [COLW-1:0] fc;
  logic [HW-1:0]   n_reg;
  logic [11:0]     nx;
  logic [15:0]     rd_data;
  logic [CNTW-1:0] total;
  logic [CNTW-1:0] copy_len;
  logic [CNTW-1:0] issued;
  logic [CNTW-1:0] rd_ptr;
  logic [CNTW-1:0] wr_ptr;
  logic            pipe_v;

  // Divider interface.
  logic              dv_start;
  logic [DIV_NW-1:0] dv_num;
  logic [DIV_DW-1:0] dv_den;
  logic              dv_done;
  logic [DIV_NW-1:0] dv_quot;
  logic [DIV_DW-1:0] dv_rem;

  // Cell store.
  logic [15:0]   mem [CELLS];
  logic [15:0]   rdata;
  logic [AW-1:0] raddr;
  logic [AW-1:0] waddr;
  logic [15:0]   wdata;
  logic          mem_we;

  logic [CW-1:0]   w_eff;
  logic [HW-1:0]   h_eff;
  logic [4:0]      t_eff;
  logic [HW-1:0]   mul_a;
  logic [PW-1:0]   prod;
  logic [CNTW-1:0] cell_idx;
  logic            in_accept;
  logic            put_store;
  logic [CW:0]     col_inc;
  logic            rd_go;
  logic [12:0]     lf_l0p1;
  logic [12:0]     lf_h;
  logic [12:0]     lf_room;
  logic [12:0]     lf_s;
  logic [LNW-1:0]  lf_line;
  logic [17:0]     tab_next;

  always_comb begin
    if (columns == 8'd0) begin
      w_eff = CW'(1);
    end else if (32'(columns) > MAX_COLUMNS) begin
      w_eff = CW'(MAX_COLUMNS);
    end else begin
      w_eff = CW'(columns);
    end
    if (rows == 6'd0) begin
      h_eff = HW'(1);
    end else if (32'(rows) > MAX_ROWS) begin
      h_eff = HW'(MAX_ROWS);
    end else begin
      h_eff = HW'(rows);
    end
    t_eff = (tab_width == 5'd0) ? 5'd1 : tab_width;
  end

  // One multiplier, always by the column count.
  always_comb begin
    case (state)
      S_SCRA:  mul_a = h_eff;
      S_SCRB:  mul_a = h_eff - n_reg;
      default: mul_a = HW'(cur_line);
    endcase
  end
  assign prod     = PW'(mul_a) * PW'(w_eff);
  assign cell_idx = prod[CNTW-1:0] + CNTW'(cur_col);

  assign in_ready  = (state == S_IDLE);
  assign in_accept = in_valid && in_ready;
  assign put_store = in_accept && (in_data.opcode == OP_PUT) && !escape &&
                     (in_data.char_code != CH_LF) && (in_data.char_code != CH_CR) &&
                     (in_data.char_code != CH_TAB) && (in_data.char_code != CH_BELL);
  assign col_inc   = (CW + 1)'(cur_col) + 1'b1;
  assign rd_go     = (issued != copy_len);
  assign tab_next  = 18'(13'(dv_quot) + 13'd1) * 18'(t_eff);

  // Line feed count folded into one scroll: rows left below the cursor are
  // used first, and every further line feed scrolls one row.
  always_comb begin
    lf_l0p1 = 13'(cur_line) + 13'd1;
    lf_h    = 13'(h_eff);
    lf_room = lf_h - lf_l0p1;
    if (lf_l0p1 >= lf_h) begin
      lf_s    = 13'(lines);
      lf_line = LNW'(h_eff - 1'b1);
    end else if (13'(lines) > lf_room) begin
      lf_s    = 13'(lines) - lf_room;
      lf_line = LNW'(h_eff - 1'b1);
    end else begin
      lf_s    = '0;
      lf_line = LNW'(13'(cur_line) + 13'(lines));
    end
  end

  // Store ports.
  always_comb begin
    mem_we = 1'b0;
    waddr  = wr_ptr[AW-1:0];
    wdata  = {attr, CH_BLANK};
    raddr  = AW'(in_data.operand);
    case (state)
      S_IDLE: begin
        mem_we = put_store;
        waddr  = cell_idx[AW-1:0];
        wdata  = {attr, in_data.char_code};
      end
      S_COPY: begin
        mem_we = pipe_v;
        wdata  = rdata;
        raddr  = rd_ptr[AW-1:0];
      end
      S_FILL: begin
        mem_we = (wr_ptr != total);
      end
      default: begin
        mem_we = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      columns       <= RESET_COLUMNS;
      rows          <= RESET_ROWS;
      tab_width     <= RESET_TAB;
      cursor_enable <= 1'b1;
    end else if (cfg_write) begin
      case (cfg_index)
        CFG_COLUMNS: columns       <= cfg_data;
        CFG_ROWS:    rows          <= cfg_data[5:0];
        CFG_TAB:     tab_width     <= cfg_data[4:0];
        CFG_CURSOR:  cursor_enable <= cfg_data[0];
        default:     columns       <= columns;
      endcase
    end
  end

  tcw_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (dv_start),
    .dividend (dv_num),
    .divisor  (dv_den),
    .done     (dv_done),
    .quot     (dv_quot),
    .rem      (dv_rem)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_FILL;
      booting   <= 1'b1;
      total     <= CNTW'(CELLS);
      wr_ptr    <= '0;
      cur_col   <= '0;
      cur_line  <= '0;
      attr      <= RESET_ATTR;
      escape    <= 1'b0;
      out_valid <= 1'b0;
      dv_start  <= 1'b0;
      pipe_v    <= 1'b0;
    end else begin
      dv_start <= 1'b0;
      if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (in_accept) begin
            rd_data <= '0;
            state   <= S_FIN;
            case (in_data.opcode)
              OP_PUT: begin
                if (escape) begin
                  attr   <= in_data.char_code;
                  escape <= 1'b0;
                end else begin
                  case (in_data.char_code)
                    CH_LF: begin
                      lines <= 12'd1;
                      fc    <= '0;
                      state <= S_LF;
                    end
                    CH_CR: cur_col <= '0;
                    CH_TAB: begin
                      dv_start <= 1'b1;
                      dv_num   <= DIV_NW'(cur_col);
                      dv_den   <= DIV_DW'(t_eff);
                      purpose  <= DP_TAB1;
                      state    <= S_DIVW;
                    end
                    CH_BELL: escape <= 1'b1;
                    default: begin
                      if (col_inc >= (CW + 1)'(w_eff)) begin
                        lines <= 12'd1;
                        fc    <= '0;
                        state <= S_LF;
                      end else begin
                        cur_col <= COLW'(col_inc);
                      end
                    end
                  endcase
                end
              end
              OP_CLEAR: begin
                cur_col  <= '0;
                cur_line <= '0;
                n_reg    <= h_eff;
                state    <= S_SCRA;
              end
              OP_SCROLL: begin
                if (32'(in_data.operand) >= 32'(h_eff)) begin
                  cur_col  <= '0;
                  cur_line <= '0;
                  n_reg    <= h_eff;
                  state    <= S_SCRA;
                end else begin
                  cur_col  <= '0;
                  cur_line <= LNW'(h_eff - 1'b1);
                  n_reg    <= HW'(in_data.operand);
                  if (in_data.operand != 12'd0) begin
                    state <= S_SCRA;
                  end
                end
              end
              OP_SETCOL: begin
                dv_start <= 1'b1;
                dv_num   <= in_data.operand;
                dv_den   <= DIV_DW'(w_eff);
                purpose  <= DP_COL;
                state    <= S_DIVW;
              end
              OP_SETROW: begin
                dv_start <= 1'b1;
                dv_num   <= in_data.operand;
                dv_den   <= DIV_DW'(h_eff);
                purpose  <= DP_ROW;
                state    <= S_DIVW;
              end
              OP_ATTR: attr <= in_data.operand[7:0];
              OP_READ: begin
                if (32'(in_data.operand) < CELLS) begin
                  state <= S_RD;
                end
              end
              default: state <= S_FIN;
            endcase
          end
        end
        S_DIVW: begin
          if (dv_done) begin
            case (purpose)
              DP_COL: begin
                cur_col <= COLW'(dv_rem);
                state   <= S_FIN;
              end
              DP_ROW: begin
                cur_line <= LNW'(dv_rem);
                state    <= S_FIN;
              end
              DP_TAB1: begin
                nx    <= 12'(tab_next);
                state <= S_TAB;
              end
              default: begin
                lines <= dv_quot;
                fc    <= COLW'(dv_rem);
                state <= S_LF;
              end
            endcase
          end
        end
        S_TAB: begin
          if (nx >= 12'(w_eff)) begin
            dv_start <= 1'b1;
            dv_num   <= nx;
            dv_den   <= DIV_DW'(w_eff);
            purpose  <= DP_TAB2;
            state    <= S_DIVW;
          end else begin
            cur_col <= COLW'(nx);
            state   <= S_FIN;
          end
        end
        S_LF: begin
          cur_col  <= fc;
          cur_line <= lf_line;
          if (lf_s == 13'd0) begin
            state <= S_FIN;
          end else begin
            n_reg <= (lf_s >= lf_h) ? h_eff : HW'(lf_s);
            state <= S_SCRA;
          end
        end
        S_SCRA: begin
          total <= prod[CNTW-1:0];
          state <= S_SCRB;
        end
        S_SCRB: begin
          copy_len <= prod[CNTW-1:0];
          rd_ptr   <= total - prod[CNTW-1:0];
          wr_ptr   <= '0;
          issued   <= '0;
          pipe_v   <= 1'b0;
          state    <= S_COPY;
        end
        S_COPY: begin
          // Reads run ahead of the writes they feed: read data is written the cycle after.
          pipe_v <= rd_go;
          if (rd_go) begin
            rd_ptr <= rd_ptr + 1'b1;
            issued <= issued + 1'b1;
          end
          if (pipe_v) begin
            wr_ptr <= wr_ptr + 1'b1;
          end
          if (!rd_go && !pipe_v) begin
            state <= S_FILL;
          end
        end
        S_FILL: begin
          if (wr_ptr != total) begin
            wr_ptr <= wr_ptr + 1'b1;
          end else begin
            booting <= 1'b0;
            state   <= booting ? S_IDLE : S_FIN;
          end
        end
        S_RD: begin
          rd_data <= rdata;
          state   <= S_FIN;
        end
        S_FIN: begin
          if (!out_valid || out_ready) begin
            out_valid               <= 1'b1;
            out_data.cursor_col     <= 7'(cur_col);
            out_data.cursor_row     <= 5'(cur_line);
            out_data.cursor_offset  <= 12'(cell_idx);
            out_data.cursor_visible <= cursor_enable;
            out_data.current_attr   <= attr;
            out_data.escape_pending <= escape;
            out_data.read_data      <= rd_data;
            state                   <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // Every accepted word makes the sequencer busy in the next cycle.
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    in_accept |=> !in_ready)
    else $error("input taken twice in a row");

  // The store is written only by a character put or by a sweep.
  a_write_source: assert property (@(posedge clk) disable iff (rst)
    mem_we |-> (state == S_IDLE || state == S_COPY || state == S_FILL))
    else $error("store written outside a put or sweep");

  // A new output word is loaded only from the finishing step.
  a_out_from_fin: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(state) == S_FIN)
    else $error("output word raised outside finish");

endmodule

`default_nettype wire

// ----- bench/text_console_writer_top_tb.sv -----
// ---------------------------------------------------------------------------
// text_console_writer_top_tb: self-checking bench for the text console writer
// Drives put-char, clear, scroll, cursor, attribute and read words through
// several screen geometries, predicts every output word from a private copy
// of the screen and cursor, and compares each received word field by field.
// ---------------------------------------------------------------------------
`default_nettype none

module text_console_writer_top_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import tcw_pkg::*;

  localparam logic [2:0] OP_NOP = 3'd7;
  localparam int CELLS = 128 * 32;
  localparam int STALL_LIMIT = 20000;

  // Screen and cursor predictor with the queue of words still owed by the DUT.
  class console_scoreboard;
    logic [15:0] cells[CELLS];
    int col, line, attr, esc;
    int columns, rows, tab, cur_en;
    tcw_out_t owed[$];
    int errors;
    int words_checked;

    function new();
      for (int i = 0; i < CELLS; i++) cells[i] = 16'h0720;
      col = 0; line = 0; attr = RESET_ATTR; esc = 0;
      columns = RESET_COLUMNS; rows = RESET_ROWS; tab = RESET_TAB; cur_en = 1;
      errors = 0; words_checked = 0;
    endfunction

    function int width();
      return columns == 0 ? 1 : (columns > 128 ? 128 : columns);
    endfunction

    function int height();
      return rows == 0 ? 1 : (rows > 32 ? 32 : rows);
    endfunction

    function logic [15:0] blank();
      return {attr[7:0], CH_BLANK};
    endfunction

    function void set_reg(logic [1:0] idx, logic [7:0] val);
      case (idx)
        CFG_COLUMNS: columns = val;
        CFG_ROWS:    rows = val[5:0];
        CFG_TAB:     tab = val[4:0];
        CFG_CURSOR:  cur_en = val[0];
        default: ;
      endcase
    endfunction

    function void wipe();
      for (int i = 0; i < width() * height() && i < CELLS; i++) cells[i] = blank();
      col = 0; line = 0;
    endfunction

    function void scroll(int n);
      int w, h, i;
      w = width(); h = height();
      if (n >= h) begin
        wipe();
        return;
      end
      for (i = 0; i < w * (h - n); i++) cells[i] = cells[i + w * n];
      for (; i < w * h; i++) cells[i] = blank();
      line = h - 1; col = 0;
    endfunction

    function void newline();
      line++;
      col = 0;
      if (line >= height()) scroll(1);
    endfunction

    function void put(logic [7:0] c);
      int w, t, nx, idx;
      w = width();
      if (esc != 0) begin
        attr = c; esc = 0;
        return;
      end
      case (c)
        CH_LF: newline();
        CH_CR: col = 0;
        CH_TAB: begin
          t = tab == 0 ? 1 : tab;
          nx = (col / t + 1) * t;
          if (nx >= w) begin
            for (int k = 0; k < nx / w; k++) newline();
            col = nx % w;
          end else begin
            col = nx;
          end
        end
        CH_BELL: esc = 1;
        default: begin
          idx = line * w + col;
          if (idx < CELLS) cells[idx] = {attr[7:0], c};
          col++;
          if (col >= w) newline();
        end
      endcase
    endfunction

    function void note_input(tcw_in_t it);
      tcw_out_t e;
      logic [15:0] rd;
      int ofs;
      rd = '0;
      case (it.opcode)
        OP_PUT:    put(it.char_code);
        OP_CLEAR:  wipe();
        OP_SCROLL: scroll(it.operand);
        OP_SETCOL: col = it.operand % width();
        OP_SETROW: line = it.operand % height();
        OP_ATTR:   attr = it.operand[7:0];
        OP_READ:   rd = cells[it.operand];
        default: ;
      endcase
      ofs = line * width() + col;
      e.cursor_col = col[6:0];
      e.cursor_row = line[4:0];
      e.cursor_offset = ofs[11:0];
      e.cursor_visible = cur_en[0];
      e.current_attr = attr[7:0];
      e.escape_pending = esc[0];
      e.read_data = rd;
      owed.push_back(e);
    endfunction

    task report(string what, int got, int want);
      errors++;
      $display("MISMATCH word %0d: %s got 0x%0h want 0x%0h", words_checked, what, got, want);
    endtask

    task check_result(tcw_out_t got);
      tcw_out_t e;
      if (owed.size() == 0) begin
        report("word with nothing owed", 0, 0);
        return;
      end
      e = owed.pop_front();
      if (got.cursor_col != e.cursor_col) report("cursor_col", got.cursor_col, e.cursor_col);
      if (got.cursor_row != e.cursor_row) report("cursor_row", got.cursor_row, e.cursor_row);
      if (got.cursor_offset != e.cursor_offset)
        report("cursor_offset", got.cursor_offset, e.cursor_offset);
      if (got.cursor_visible != e.cursor_visible)
        report("cursor_visible", got.cursor_visible, e.cursor_visible);
      if (got.current_attr != e.current_attr)
        report("current_attr", got.current_attr, e.current_attr);
      if (got.escape_pending != e.escape_pending)
        report("escape_pending", got.escape_pending, e.escape_pending);
      if (got.read_data != e.read_data) report("read_data", got.read_data, e.read_data);
      words_checked++;
    endtask
  endclass

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_ready;
  tcw_in_t in_data = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  tcw_out_t out_data;
  logic cfg_write = 1'b0;
  logic [1:0] cfg_index = '0;
  logic [7:0] cfg_data = '0;

  console_scoreboard sb = new();
  int words_sent = 0;
  int idle_cycles = 0;
  bit quiet = 1'b0;
  bit hold_out = 1'b0;

  text_console_writer_top u_dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
    .cfg_write(cfg_write), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always #5 clk = ~clk;

  task send_word(tcw_in_t it);
    if (!quiet && $urandom_range(99) < 14) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(6, 1)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= it;
    // Ready is sampled at the edge itself, before the block updates.
    @(posedge clk iff in_ready);
    sb.note_input(it);
    words_sent++;
  endtask

  task write_reg(logic [1:0] idx, logic [7:0] val);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    sb.set_reg(idx, val);
  endtask

  task wait_drained();
    in_valid <= 1'b0;
    while (sb.owed.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
  endtask

  function tcw_in_t make_word(logic [2:0] op, logic [7:0] ch, logic [11:0] arg);
    tcw_in_t it;
    it.opcode = op; it.char_code = ch; it.operand = arg;
    return it;
  endfunction

  function tcw_in_t random_word();
    int pick, area;
    tcw_in_t it;
    it.opcode = OP_PUT;
    it.char_code = $urandom_range(255);
    it.operand = $urandom_range(4095);
    area = sb.width() * sb.height();
    pick = $urandom_range(99);
    if (pick < 30) it.char_code = $urandom_range(126, 32);
    else if (pick < 40) it.char_code = CH_LF;
    else if (pick < 45) it.char_code = CH_CR;
    else if (pick < 52) it.char_code = CH_TAB;
    else if (pick < 57) it.char_code = CH_BELL;
    else if (pick < 62) ;
    else if (pick < 64) it.opcode = OP_CLEAR;
    else if (pick < 69) begin
      it.opcode = OP_SCROLL;
      if ($urandom_range(3) != 0) it.operand = $urandom_range(sb.height());
    end else if (pick < 75) it.opcode = OP_SETCOL;
    else if (pick < 81) it.opcode = OP_SETROW;
    else if (pick < 85) it.opcode = OP_ATTR;
    else if (pick < 98) begin
      it.opcode = OP_READ;
      if ($urandom_range(3) != 0) it.operand = $urandom_range(area - 1);
    end else it.opcode = OP_NOP;
    return it;
  endfunction

  // Receiver: random back-pressure, plus a long hold while pressure is on.
  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) sb.check_result(out_data);
    out_ready <= !hold_out && (quiet || $urandom_range(99) >= 14);
  end

  // Holds the output off long enough for the block to back up into its input.
  initial begin
    wait (words_sent >= 60);
    @(posedge clk);
    hold_out = 1'b1;
    repeat (400) @(posedge clk);
    hold_out = 1'b0;
  end

  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= STALL_LIMIT) begin
      $display("watchdog expired after %0d words sent", words_sent);
      $display("text_console_writer_top: mismatch");
      $finish;
    end
  end

  initial begin
    logic [7:0] geom[9][4];
    int counts[9];
    geom = '{'{8'd8, 8'd4, 8'd4, 8'd1}, '{8'd1, 8'd1, 8'd1, 8'd0},
             '{8'd0, 8'd0, 8'd0, 8'd1}, '{8'd16, 8'd8, 8'd16, 8'd0},
             '{8'd5, 8'd3, 8'd3, 8'd1}, '{8'd128, 8'd2, 8'd7, 8'd1},
             '{8'd3, 8'd32, 8'd2, 8'd1}, '{8'd255, 8'd63, 8'd31, 8'd1},
             '{8'd12, 8'd6, 8'd5, 8'd1}};
    counts = '{90, 50, 50, 80, 90, 60, 60, 15, 90};
    repeat (10) @(posedge clk);
    rst <= 1'b0;

    send_word(make_word(OP_PUT, 8'h41, 12'd0));
    send_word(make_word(OP_PUT, 8'hff, 12'hfff));
    send_word(make_word(OP_PUT, 8'h00, 12'd0));
    send_word(make_word(OP_PUT, CH_CR, 12'd0));
    send_word(make_word(OP_PUT, CH_TAB, 12'd0));
    send_word(make_word(OP_PUT, CH_LF, 12'd0));
    send_word(make_word(OP_PUT, CH_BELL, 12'd0));
    send_word(make_word(OP_PUT, 8'h1e, 12'd0));
    send_word(make_word(OP_PUT, CH_BELL, 12'd0));
    send_word(make_word(OP_SETCOL, 8'h00, 12'd3));
    send_word(make_word(OP_PUT, 8'h41, 12'd0));
    send_word(make_word(OP_SETCOL, 8'h00, 12'hfff));
    send_word(make_word(OP_PUT, 8'h58, 12'd0));
    send_word(make_word(OP_SETROW, 8'h00, 12'hfff));
    send_word(make_word(OP_PUT, CH_LF, 12'd0));
    send_word(make_word(OP_ATTR, 8'h00, 12'hfff));
    send_word(make_word(OP_READ, 8'h00, 12'd0));
    send_word(make_word(OP_READ, 8'h00, 12'hfff));
    send_word(make_word(OP_SCROLL, 8'h00, 12'd0));
    send_word(make_word(OP_SCROLL, 8'h00, 12'd1));
    send_word(make_word(OP_READ, 8'h00, 12'd1920));
    send_word(make_word(OP_SCROLL, 8'h00, 12'd25));
    send_word(make_word(OP_CLEAR, 8'h00, 12'd0));
    send_word(make_word(OP_NOP, 8'hff, 12'hfff));
    wait_drained();

    for (int p = 0; p < 9; p++) begin
      // The cursor may be left outside a shrunken screen on purpose.
      for (int r = 0; r < 4; r++) write_reg(r[1:0], geom[p][r]);
      cfg_write <= 1'b0;
      quiet = (p == 3);
      for (int n = 0; n < counts[p]; n++) send_word(random_word());
      wait_drained();
    end

    repeat (20) @(posedge clk);
    $display("sent %0d words over nine screen geometries, checked %0d output words",
             words_sent, sb.words_checked);
    $display("geometry clamps, tabs, wraps, escapes, scrolls and cell reads exercised");
    if (sb.errors == 0 && sb.owed.size() == 0) begin
      $display("text_console_writer_top: match");
    end else begin
      $display("text_console_writer_top: mismatch");
    end
    $finish;
  end

endmodule

`default_nettype wire

// ----- text_console_writer_top.f -----
rtl/core/tcw_pkg.sv
rtl/core/tcw_div.sv
rtl/core/text_console_writer_top.sv
bench/text_console_writer_top_tb.sv
